// ----- rtl/core/ppu_pkg.sv -----
// Shared types and constants for the projectile pool update block.
package ppu_pkg;

   localparam int unsigned MODE_W  = 3;
   localparam int unsigned POS_W   = 21;
   localparam int unsigned DIR_W   = 16;
   localparam int unsigned DT_W    = 16;
   localparam int unsigned LAYER_W = 2;
   localparam int unsigned IDXIN_W = 6;
   localparam int unsigned PIX_W   = 13;
   localparam int unsigned CFG_W   = 12;
   localparam int unsigned CSR_A_W = 2;

   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TICK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIRE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEACT = 3'd4;

   localparam logic [CSR_A_W-1:0] CSR_SPEED_NORMAL = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_SPEED_BOSS   = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_BOUND_RIGHT  = 2'd2;
   localparam logic [CSR_A_W-1:0] CSR_BOUND_BOTTOM = 2'd3;

   localparam logic [LAYER_W-1:0] LAYER_BOSS = 2'd2;

   localparam logic signed [POS_W-1:0] POS_MAX = 21'sd1048575;
   localparam logic signed [POS_W-1:0] POS_MIN = -21'sd1048576;

   typedef struct packed {
      logic load_req;
      logic cnt_clr;
      logic cnt_inc;
      logic exec;
      logic fire_wr;
      logic tick_issue;
      logic query_rd;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_free;
      logic cnt_last;
      logic pipe_empty;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/core/ppu_ctrl.sv -----
// Command sequencer for the projectile pool.
module ppu_ctrl
   import ppu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_stall,
   input  status_type        status,
   output cmd_type           cmd
);

   typedef enum logic [2:0] {
      IDLE, EXEC, SCAN, TICK, DRAIN, QREAD, FINISH
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.cnt_clr  = 1'b1;
               case (req_mode)
                  MODE_CLEAR: state_in = EXEC;
                  MODE_DEACT: state_in = EXEC;
                  MODE_TICK:  state_in = TICK;
                  MODE_FIRE:  state_in = SCAN;
                  MODE_QUERY: state_in = QREAD;
                  default:    state_in = FINISH;
               endcase
            end
         end
         EXEC: begin
            cmd.exec = 1'b1;
            state_in = FINISH;
         end
         SCAN: begin
            if (status.scan_free) begin
               cmd.fire_wr = 1'b1;
               state_in    = FINISH;
            end else if (status.cnt_last) begin
               state_in = FINISH;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         TICK: begin
            cmd.tick_issue = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (status.cnt_last) state_in = DRAIN;
         end
         DRAIN: begin
            if (status.pipe_empty) state_in = FINISH;
         end
         QREAD: begin
            cmd.query_rd = 1'b1;
            state_in     = FINISH;
         end
         FINISH: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   a_tick_only_in_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_issue |-> !req_stall || state_ff == TICK)
      else $error("tick issue outside tick walk");
   a_drain_follows_tick: assert property (@(posedge clock) disable iff (reset)
      state_ff == DRAIN |-> $past(state_ff) == TICK || $past(state_ff) == DRAIN)
      else $error("drain entered without a tick walk");
   a_finish_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FINISH && status.out_free) |=> state_ff == IDLE)
      else $error("finish did not release");

endmodule

// ----- rtl/core/ppu_datapath.sv -----
// Pool storage, motion pipeline, fire scan and result register.
module ppu_datapath
   import ppu_pkg::*;
#(
   parameter int unsigned POOL_SIZE = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic                      csr_write,
   input  logic [CSR_A_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]          csr_wdata,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [DT_W-1:0]           req_dt,
   input  logic [LAYER_W-1:0]        req_layer,
   input  logic signed [POS_W-1:0]   req_start_x,
   input  logic signed [POS_W-1:0]   req_start_y,
   input  logic signed [DIR_W-1:0]   req_dir_x,
   input  logic signed [DIR_W-1:0]   req_dir_y,
   input  logic [IDXIN_W-1:0]        req_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_fired,
   output logic [IDXIN_W-1:0]        rsp_slot,
   output logic                      rsp_is_active,
   output logic signed [PIX_W-1:0]   rsp_pos_x,
   output logic signed [PIX_W-1:0]   rsp_pos_y,
   output logic [LAYER_W-1:0]        rsp_layer_out
);

   localparam int unsigned IDX_W  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int unsigned M1_W   = DIR_W + CFG_W;
   localparam int unsigned M2_W   = M1_W + DT_W + 1;
   localparam int unsigned SUM_W  = POS_W + 4;
   localparam int unsigned WIDE_W = 9;

   // configuration
   logic [CFG_W-1:0] spd_norm_ff, spd_boss_ff, bnd_r_ff, bnd_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spd_norm_ff <= '0;
         spd_boss_ff <= '0;
         bnd_r_ff    <= '1;
         bnd_b_ff    <= '1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SPEED_NORMAL: spd_norm_ff <= csr_wdata;
            CSR_SPEED_BOSS:   spd_boss_ff <= csr_wdata;
            CSR_BOUND_RIGHT:  bnd_r_ff    <= csr_wdata;
            CSR_BOUND_BOTTOM: bnd_b_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // latched request beat
   logic [MODE_W-1:0]       mode_ff;
   logic [DT_W-1:0]         dt_ff;
   logic [LAYER_W-1:0]      layer_ff;
   logic signed [POS_W-1:0] sx_ff, sy_ff;
   logic signed [DIR_W-1:0] dx_ff, dy_ff;
   logic [IDXIN_W-1:0]      idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff  <= req_mode;
         dt_ff    <= req_dt;
         layer_ff <= req_layer;
         sx_ff    <= req_start_x;
         sy_ff    <= req_start_y;
         dx_ff    <= req_dir_x;
         dy_ff    <= req_dir_y;
         idx_ff   <= req_index;
      end
   end

   logic [WIDE_W-1:0] idx_wide;
   logic              idx_ok;
   logic [IDX_W-1:0]  idx_addr;

   assign idx_wide = WIDE_W'(idx_ff);
   assign idx_ok   = idx_wide < WIDE_W'(POOL_SIZE);
   assign idx_addr = idx_wide[IDX_W-1:0];

   // walk counter shared by fire scan and tick issue
   logic [IDX_W-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc && !status.cnt_last) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // active bits and storage
   logic [POOL_SIZE-1:0]    act_ff;
   logic signed [POS_W-1:0] px_mem [POOL_SIZE];
   logic signed [POS_W-1:0] py_mem [POOL_SIZE];
   logic signed [DIR_W-1:0] dx_mem [POOL_SIZE];
   logic signed [DIR_W-1:0] dy_mem [POOL_SIZE];
   logic [LAYER_W-1:0]      ly_mem [POOL_SIZE];

   logic [IDX_W-1:0]        rd_addr;
   logic signed [POS_W-1:0] rd_px_ff, rd_py_ff;
   logic signed [DIR_W-1:0] rd_dx_ff, rd_dy_ff;
   logic [LAYER_W-1:0]      rd_ly_ff;

   assign rd_addr = cmd.tick_issue ? cnt_ff : idx_addr;

   // motion pipeline
   logic                    v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]        a1_ff, a2_ff, a3_ff;
   logic signed [POS_W-1:0] p2x_ff, p2y_ff, p3x_ff, p3y_ff;
   logic signed [M1_W-1:0]  m1x_ff, m1y_ff;
   logic signed [M2_W-1:0]  m2x_ff, m2y_ff;
   logic [CFG_W-1:0]        spd;

   assign spd = (rd_ly_ff == LAYER_BOSS) ? spd_boss_ff : spd_norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.tick_issue && act_ff[cnt_ff];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff  <= cnt_ff;
      a2_ff  <= a1_ff;
      a3_ff  <= a2_ff;
      p2x_ff <= rd_px_ff;
      p2y_ff <= rd_py_ff;
      p3x_ff <= p2x_ff;
      p3y_ff <= p2y_ff;
      m1x_ff <= M1_W'(rd_dx_ff) * M1_W'($signed({1'b0, spd}));
      m1y_ff <= M1_W'(rd_dy_ff) * M1_W'($signed({1'b0, spd}));
      m2x_ff <= M2_W'(m1x_ff) * M2_W'($signed({1'b0, dt_ff}));
      m2y_ff <= M2_W'(m1y_ff) * M2_W'($signed({1'b0, dt_ff}));
   end

   function automatic logic signed [POS_W-1:0] move_sat(
      input logic signed [POS_W-1:0] pos,
      input logic signed [M2_W-1:0]  prod
   );
      logic signed [M2_W:0]    t;
      logic signed [SUM_W-1:0] n;
      t = $signed({prod[M2_W-1], prod}) + (M2_W+1)'(2 ** 21);
      n = SUM_W'(t >>> 22) + SUM_W'(pos);
      if (n > SUM_W'(POS_MAX)) move_sat = POS_MAX;
      else if (n < SUM_W'(POS_MIN)) move_sat = POS_MIN;
      else move_sat = n[POS_W-1:0];
   endfunction

   logic signed [POS_W-1:0] nx, ny;
   logic                    retire;

   assign nx = move_sat(p3x_ff, m2x_ff);
   assign ny = move_sat(p3y_ff, m2y_ff);
   assign retire = nx[POS_W-1] || ny[POS_W-1]
                || (nx > $signed({1'b0, bnd_r_ff, 8'd0}))
                || (ny > $signed({1'b0, bnd_b_ff, 8'd0}));

   always_ff @(posedge clock) begin
      if (cmd.fire_wr) begin
         px_mem[cnt_ff] <= sx_ff;
         py_mem[cnt_ff] <= sy_ff;
         dx_mem[cnt_ff] <= dx_ff;
         dy_mem[cnt_ff] <= dy_ff;
         ly_mem[cnt_ff] <= layer_ff;
      end else if (v3_ff) begin
         px_mem[a3_ff] <= nx;
         py_mem[a3_ff] <= ny;
      end
      rd_px_ff <= px_mem[rd_addr];
      rd_py_ff <= py_mem[rd_addr];
      rd_dx_ff <= dx_mem[rd_addr];
      rd_dy_ff <= dy_mem[rd_addr];
      rd_ly_ff <= ly_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
      end else if (cmd.exec && mode_ff == MODE_CLEAR) begin
         act_ff <= '0;
      end else begin
         if (cmd.exec && mode_ff == MODE_DEACT && idx_ok) act_ff[idx_addr] <= 1'b0;
         if (cmd.fire_wr) act_ff[cnt_ff] <= 1'b1;
         if (v3_ff && retire) act_ff[a3_ff] <= 1'b0;
      end
   end

   // fire and query results
   logic fired_ff, q_act_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         fired_ff <= 1'b0;
      end else if (cmd.fire_wr) begin
         fired_ff <= 1'b1;
      end
      if (cmd.query_rd) q_act_ff <= idx_ok && act_ff[idx_addr];
   end

   function automatic logic signed [PIX_W-1:0] to_pixels(input logic signed [POS_W-1:0] q);
      logic signed [POS_W-1:0] adj;
      adj = q + (q[POS_W-1] ? POS_W'(255) : POS_W'(0));
      to_pixels = adj[POS_W-1:8];
   endfunction

   // output register
   logic                    rsp_valid_ff, fired_o_ff, act_o_ff;
   logic [IDXIN_W-1:0]      slot_o_ff;
   logic signed [PIX_W-1:0] px_o_ff, py_o_ff;
   logic [LAYER_W-1:0]      ly_o_ff;
   logic [WIDE_W-1:0]       cnt_wide;

   assign cnt_wide = WIDE_W'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         fired_o_ff <= 1'b0;
         slot_o_ff  <= '0;
         act_o_ff   <= 1'b0;
         px_o_ff    <= '0;
         py_o_ff    <= '0;
         ly_o_ff    <= '0;
         if (mode_ff == MODE_FIRE && fired_ff) begin
            fired_o_ff <= 1'b1;
            slot_o_ff  <= cnt_wide[IDXIN_W-1:0];
         end else if (mode_ff == MODE_QUERY && idx_ok) begin
            act_o_ff <= q_act_ff;
            px_o_ff  <= to_pixels(rd_px_ff);
            py_o_ff  <= to_pixels(rd_py_ff);
            ly_o_ff  <= q_act_ff ? rd_ly_ff : '0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fired     = fired_o_ff;
   assign rsp_slot      = slot_o_ff;
   assign rsp_is_active = act_o_ff;
   assign rsp_pos_x     = px_o_ff;
   assign rsp_pos_y     = py_o_ff;
   assign rsp_layer_out = ly_o_ff;

   assign status.scan_free  = !act_ff[cnt_ff];
   assign status.cnt_last   = (cnt_ff == IDX_W'(POOL_SIZE - 1));
   assign status.pipe_empty = !(v1_ff || v2_ff || v3_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fire_wr && v3_ff))
      else $error("fire write collides with tick writeback");
   a_fire_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fire_wr |=> act_ff[$past(cnt_ff)])
      else $error("fired slot not marked active");
   a_rsp_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.pipe_empty)
      else $error("result loaded with motion in flight");

endmodule

// ----- rtl/core/projectile_pool_update.sv -----
// Top level of the projectile pool update block.
//
// Input channel req_*: one command beat per item (clear, tick, fire, query,
// deactivate), accepted when req_valid is high and req_stall is low.
// Result channel rsp_*: exactly one result beat per command, in order.
// Configuration port csr_*: speeds and play-area bounds, written while idle.
//
// Fire scans the slots in order and stops at the first free one or at the last
// slot, visiting up to POOL_SIZE; tick walks all POOL_SIZE slots and then waits
// for the motion pipeline to drain. Every slot is visited by a single counter
// through one storage read port and a multiply pipeline (read, speed, dt), so a
// tick issues one slot per cycle. One command is in work at a time; the next is
// accepted the cycle after the result is loaded into the output register.
//
// Reset clears all active bits and restores the configuration defaults.
// When the receiver stalls, the result beat holds in the output register
// and a finished command waits until that register is free.
module projectile_pool_update
   import ppu_pkg::*;
#(
   parameter int unsigned POOL_SIZE = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [DT_W-1:0]           req_dt,
   input  logic [LAYER_W-1:0]        req_layer,
   input  logic signed [POS_W-1:0]   req_start_x,
   input  logic signed [POS_W-1:0]   req_start_y,
   input  logic signed [DIR_W-1:0]   req_dir_x,
   input  logic signed [DIR_W-1:0]   req_dir_y,
   input  logic [IDXIN_W-1:0]        req_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_fired,
   output logic [IDXIN_W-1:0]        rsp_slot,
   output logic                      rsp_is_active,
   output logic signed [PIX_W-1:0]   rsp_pos_x,
   output logic signed [PIX_W-1:0]   rsp_pos_y,
   output logic [LAYER_W-1:0]        rsp_layer_out,
   input  logic                      csr_write,
   input  logic [CSR_A_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]          csr_wdata
);

   cmd_type    cmd;
   status_type status;

   ppu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ppu_datapath #(.POOL_SIZE(POOL_SIZE)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_mode      (req_mode),
      .req_dt        (req_dt),
      .req_layer     (req_layer),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_dir_x     (req_dir_x),
      .req_dir_y     (req_dir_y),
      .req_index     (req_index),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_fired     (rsp_fired),
      .rsp_slot      (rsp_slot),
      .rsp_is_active (rsp_is_active),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_layer_out (rsp_layer_out)
   );

endmodule
